// File: sv/kmp_pkg.sv
// Shared types and constants for the KMP pattern matcher.
package kmp_pkg;

  localparam int unsigned MaxPatternDef = 64;
  localparam int unsigned PosBitsDef    = 16;
  localparam int unsigned StartW        = 16;

  localparam logic FuncPattern = 1'b0;
  localparam logic FuncText    = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] symbol;
    logic       last;
  } kmp_req_t;

  typedef struct packed {
    logic              found;
    logic [StartW-1:0] start_pos;
    logic              pattern_truncated;
    logic              position_saturated;
  } kmp_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;       // take the offered request and do its first step
    logic step;        // fall back one entry through the prefix table
    logic pat_done;    // finish a pattern byte
    logic hit;         // a text match: fetch the fallback of the full length
    logic emit;        // finish a text byte without a match
    logic emit_match;  // finish a text byte with a match
  } kmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_text;     // offered request is a text byte
    logic pat_walk;    // offered pattern byte needs a fallback walk
    logic is_text;     // request in progress is a text byte
    logic walk_more;   // current candidate mismatches and can fall back
    logic hit;         // text byte completes the pattern
  } kmp_status_t;

endpackage

// File: sv/kmp_datapath.sv
// Datapath of the KMP matcher: pattern and prefix memories, match state, result register.
module kmp_datapath import kmp_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef,
  parameter int unsigned POS_BITS    = PosBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kmp_req_t    in_req_i,
  input  kmp_cmd_t    cmd_i,
  output kmp_status_t status_o,
  output kmp_rsp_t    out_rsp_o
);

  localparam int unsigned IdxW = $clog2(MAX_PATTERN);
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CmpW = (POS_BITS > LenW) ? POS_BITS : LenW;

  logic [7:0]      store_mem [MAX_PATTERN];
  logic [IdxW-1:0] prefix_mem [MAX_PATTERN];
  logic [7:0]      store_rd;
  logic [IdxW-1:0] prefix_rd;

  logic [LenW-1:0]     len_q, len_d, matched_q, matched_d, k_q, k_d;
  logic [IdxW-1:0]     build_q, build_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                complete_q, complete_d, trunc_q, trunc_d;
  logic [7:0]          sym_q, sym_d;
  logic                last_q, last_d, func_q, func_d;
  kmp_rsp_t            out_q, out_d;

  logic            st_we, pf_we;
  logic [IdxW-1:0] st_waddr, pf_waddr, pf_wdata, rd_addr, pf_raddr;
  logic [7:0]      st_wdata;
  logic [LenW-1:0] len_eff, jf, build_ext, prefix_ext, k_dec;
  logic [CmpW-1:0] pos_ext, lenm1_ext, start_diff;
  logic [CmpW+StartW-1:0] start_wide;
  logic            pos_max;

  assign len_eff    = complete_q ? '0 : len_q;
  assign jf         = k_q + LenW'(store_rd == sym_q);
  assign build_ext  = LenW'(build_q);
  assign prefix_ext = LenW'(prefix_rd);
  assign pos_max    = (pos_q == '1);

  // Start position of an occurrence that ends here; clamped at zero.
  assign pos_ext    = CmpW'(pos_q);
  assign lenm1_ext  = CmpW'(len_q - LenW'(1));
  assign start_diff = (pos_ext >= lenm1_ext) ? (pos_ext - lenm1_ext) : '0;
  assign start_wide = {{StartW{1'b0}}, start_diff};

  assign k_dec    = k_d - LenW'(1);
  assign rd_addr  = k_d[IdxW-1:0];
  assign pf_raddr = k_dec[IdxW-1:0];

  always_comb begin
    status_o.in_text   = (in_req_i.func == FuncText);
    status_o.pat_walk  = (len_eff != '0) && (len_eff < LenW'(MAX_PATTERN));
    status_o.is_text   = (func_q == FuncText);
    status_o.walk_more = (k_q != '0) && (store_rd != sym_q);
    status_o.hit       = (func_q == FuncText) && (len_q != '0) && (jf == len_q);
  end

  always_comb begin
    len_d      = len_q;
    build_d    = build_q;
    matched_d  = matched_q;
    pos_d      = pos_q;
    complete_d = complete_q;
    trunc_d    = trunc_q;
    k_d        = k_q;
    sym_d      = sym_q;
    last_d     = last_q;
    func_d     = func_q;
    out_d      = out_q;
    st_we      = 1'b0;
    st_waddr   = len_eff[IdxW-1:0];
    st_wdata   = in_req_i.symbol;
    pf_we      = 1'b0;
    pf_waddr   = len_q[IdxW-1:0];
    pf_wdata   = jf[IdxW-1:0];

    if (cmd_i.start) begin
      sym_d  = in_req_i.symbol;
      last_d = in_req_i.last;
      func_d = in_req_i.func;
      if (in_req_i.func == FuncText) begin
        k_d = (matched_q >= len_q) ? '0 : matched_q;
      end else begin
        if (complete_q) begin
          len_d      = '0;
          build_d    = '0;
          trunc_d    = 1'b0;
          matched_d  = '0;
          pos_d      = '0;
          complete_d = 1'b0;
        end
        if (len_eff == '0) begin
          st_we    = 1'b1;
          st_waddr = '0;
          pf_we    = 1'b1;
          pf_waddr = '0;
          pf_wdata = '0;
          build_d  = '0;
          len_d    = LenW'(1);
          if (in_req_i.last) begin
            complete_d = 1'b1;
          end
        end else if (len_eff >= LenW'(MAX_PATTERN)) begin
          trunc_d = 1'b1;
          if (in_req_i.last) begin
            complete_d = 1'b1;
          end
        end else begin
          st_we = 1'b1;
          k_d   = (build_ext >= len_q) ? '0 : build_ext;
        end
      end
    end

    if (cmd_i.step) begin
      k_d = prefix_ext;
    end

    if (cmd_i.pat_done) begin
      pf_we   = 1'b1;
      build_d = jf[IdxW-1:0];
      len_d   = len_q + LenW'(1);
      if (last_q) begin
        complete_d = 1'b1;
      end
    end

    // Point the candidate at the full length so the next read fetches its fallback.
    if (cmd_i.hit) begin
      k_d = len_q;
    end

    if (cmd_i.emit) begin
      out_d.found     = 1'b0;
      out_d.start_pos = '0;
      if (len_q != '0) begin
        matched_d = jf;
      end
    end

    if (cmd_i.emit_match) begin
      out_d.found     = 1'b1;
      out_d.start_pos = start_wide[StartW-1:0];
      matched_d       = prefix_ext;
    end

    if (cmd_i.emit || cmd_i.emit_match) begin
      out_d.pattern_truncated  = trunc_q;
      out_d.position_saturated = pos_max;
      if (last_q) begin
        pos_d     = '0;
        matched_d = '0;
      end else if (!pos_max) begin
        pos_d = pos_q + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    store_rd <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pf_we) begin
      prefix_mem[pf_waddr] <= pf_wdata;
    end
    prefix_rd <= prefix_mem[pf_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      build_q    <= '0;
      matched_q  <= '0;
      pos_q      <= '0;
      complete_q <= 1'b1;
      trunc_q    <= 1'b0;
    end else begin
      len_q      <= len_d;
      build_q    <= build_d;
      matched_q  <= matched_d;
      pos_q      <= pos_d;
      complete_q <= complete_d;
      trunc_q    <= trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    sym_q  <= sym_d;
    last_q <= last_d;
    func_q <= func_d;
    out_q  <= out_d;
  end

  assign out_rsp_o = out_q;

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MAX_PATTERN))
    else $error("pattern length beyond the store");

  a_matched_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (matched_q == '0) || (matched_q < len_q))
    else $error("matched count not below pattern length");

  a_build_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (build_q == '0) || (build_ext < len_q))
    else $error("prefix build length not below pattern length");
`endif

endmodule

// File: sv/kmp_ctrl.sv
// Controller of the KMP matcher: request sequencing and result handshake.
module kmp_ctrl import kmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  kmp_status_t status_i,
  output kmp_cmd_t    cmd_o
);

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SWalk  = 2'd1;
  localparam logic [1:0] SMatch = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (status_i.in_text || status_i.pat_walk) begin
            state_d = SWalk;
          end
        end
      end
      SWalk: begin
        priority if (status_i.walk_more) begin
          cmd_o.step = 1'b1;
        end else if (!status_i.is_text) begin
          cmd_o.pat_done = 1'b1;
          state_d        = SIdle;
        end else if (status_i.hit) begin
          cmd_o.hit = 1'b1;
          state_d   = SMatch;
        end else if (out_free) begin
          // A stalled result holds the candidate, so the memories keep re-reading it.
          cmd_o.emit = 1'b1;
          state_d    = SIdle;
        end
      end
      SMatch: begin
        if (out_free) begin
          cmd_o.emit_match = 1'b1;
          state_d          = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit || cmd_o.emit_match) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_emit_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit || cmd_o.emit_match) |-> (!out_valid_q || out_ready_i))
    else $error("result written over a pending response");

  a_match_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SMatch) |-> ($past(state_q) == SWalk || $past(state_q) == SMatch))
    else $error("match state entered without a walk");

  a_match_emits_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_match |=> out_valid_o)
    else $error("match result not presented");
`endif

endmodule

// File: sv/kmp_pattern_matcher.sv
// Top level of the KMP pattern matcher: controller and datapath.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   in_req_i  (func, symbol, last)
//   out      output     out_valid_o / out_ready_i out_rsp_o (found, start_pos, flags)
//
// A pattern byte that is the first or an overflow byte is taken in the idle state alone;
// any other pattern byte walks back through the prefix table, one fallback step per cycle
// (set by the single read port of each memory), and then finishes. A text byte walks the
// same way, then passes through the match state when a match ends there. Fallbacks amortize to about one per byte.
// Reset clears all control state; the memories hold no reset value.
// A stalled response holds the next text request in its last step until the slot frees.
module kmp_pattern_matcher import kmp_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef,
  parameter int unsigned POS_BITS    = PosBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  kmp_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kmp_rsp_t out_rsp_o
);

  kmp_cmd_t    cmd;
  kmp_status_t status;

  kmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kmp_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .POS_BITS    (POS_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_rsp_o (out_rsp_o)
  );

endmodule
